// ----- src/aho_corasick_dna_matcher_defines.svh -----
// Assertion macros for the Aho-Corasick DNA matcher.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef AHO_CORASICK_DNA_MATCHER_DEFINES_SVH
`define AHO_CORASICK_DNA_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ACDM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACDM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/acdm_pkg.sv -----
// Shared types and constants for the Aho-Corasick DNA matcher.
// No dependencies; used by the interfaces, the controller and the datapath.
`default_nettype none

package acdm_pkg;

   localparam int NODE_COUNT    = 1024;
   localparam int ALPHABET_SIZE = 4;
   localparam int NODE_W        = $clog2(NODE_COUNT);
   localparam int CHILD_W       = NODE_W + 1;
   localparam int STEP_W        = $clog2(NODE_COUNT + 1);
   localparam int HIT_W         = 16;
   localparam int TOTAL_W       = 32;
   localparam int OPCODE_W      = 2;
   localparam int SYM_W         = 2;

   localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SCAN    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd2;

   // One automaton node as held in the node table; child 0 is A.
   typedef struct packed {
      logic [ALPHABET_SIZE-1:0][CHILD_W-1:0] child;
      logic [NODE_W-1:0]                     failure;
      logic [HIT_W-1:0]                      hits;
   } node_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic restart;
      logic scan_start;
      logic scan_read;
      logic walk_fail;
      logic walk_root;
      logic take_child;
      logic finish;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cache_valid;
      logic walk_needed;
      logic limit_hit;
      logic child_present;
      logic rsp_free;
   } dp_sts_type;

endpackage

`default_nettype wire

// ----- src/acdm_req_if.sv -----
// Request channel: valid/ready handshake carrying one input item.
// Depends on acdm_pkg for field widths.
`default_nettype none

interface acdm_req_if import acdm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [NODE_W-1:0]   node_index;
   logic [CHILD_W-1:0]  child_a;
   logic [CHILD_W-1:0]  child_c;
   logic [CHILD_W-1:0]  child_g;
   logic [CHILD_W-1:0]  child_t;
   logic [NODE_W-1:0]   failure_link;
   logic [HIT_W-1:0]    hit_count;
   logic [SYM_W-1:0]    symbol;

   modport source (
      output valid, opcode, node_index, child_a, child_c, child_g, child_t,
             failure_link, hit_count, symbol,
      input  ready
   );

   modport sink (
      input  valid, opcode, node_index, child_a, child_c, child_g, child_t,
             failure_link, hit_count, symbol,
      output ready
   );
endinterface

`default_nettype wire

// ----- src/acdm_rsp_if.sv -----
// Result channel: valid/ready handshake carrying one result item.
// Depends on acdm_pkg for field widths.
`default_nettype none

interface acdm_rsp_if import acdm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [HIT_W-1:0]   matches_here;
   logic [TOTAL_W-1:0] total_matches;
   logic [NODE_W-1:0]  current_state;

   modport source (
      output valid, matches_here, total_matches, current_state,
      input  ready
   );

   modport sink (
      input  valid, matches_here, total_matches, current_state,
      output ready
   );
endinterface

`default_nettype wire

// ----- src/acdm_ctrl.sv -----
// Controller state machine for the Aho-Corasick DNA matcher.
// Depends on acdm_pkg; drives commands into acdm_datapath.
`default_nettype none

module acdm_ctrl import acdm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OPCODE_W-1:0] req_opcode,
   output logic                req_ready,
   input  dp_sts_type          sts,
   output ctl_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EVAL   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_opcode)
                  OP_LOAD:    cmd.load = 1'b1;
                  OP_RESTART: cmd.restart = 1'b1;
                  OP_SCAN: begin
                     cmd.scan_start = 1'b1;
                     cmd.scan_read  = !sts.cache_valid;
                     state_in       = ST_EVAL;
                  end
                  default: ;
               endcase
            end
         end
         ST_EVAL: begin
            if (sts.walk_needed) begin
               // fall back once the step budget is spent
               if (sts.limit_hit) begin
                  cmd.walk_root = 1'b1;
               end else begin
                  cmd.walk_fail = 1'b1;
               end
            end else begin
               cmd.take_child = sts.child_present;
               state_in       = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/acdm_datapath.sv -----
// Datapath of the Aho-Corasick DNA matcher: node table, walk registers,
// saturating total and result register. Depends on acdm_pkg.
`default_nettype none

module acdm_datapath import acdm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ctl_cmd_type        cmd,
   output dp_sts_type         sts,
   input  logic [NODE_W-1:0]  req_node_index,
   input  logic [CHILD_W-1:0] req_child_a,
   input  logic [CHILD_W-1:0] req_child_c,
   input  logic [CHILD_W-1:0] req_child_g,
   input  logic [CHILD_W-1:0] req_child_t,
   input  logic [NODE_W-1:0]  req_failure_link,
   input  logic [HIT_W-1:0]   req_hit_count,
   input  logic [SYM_W-1:0]   req_symbol,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [HIT_W-1:0]   rsp_matches_here,
   output logic [TOTAL_W-1:0] rsp_total_matches,
   output logic [NODE_W-1:0]  rsp_current_state
);

   node_entry_type node_mem [NODE_COUNT];
   node_entry_type rd_data_ff;
   node_entry_type wr_entry;

   logic [NODE_W-1:0]  node_ff, node_in;
   logic [NODE_W-1:0]  scan_node_ff, scan_node_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [SYM_W-1:0]   sym_ff;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic               cache_valid_ff, cache_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [HIT_W-1:0]   rsp_hits_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic [NODE_W-1:0]  rsp_node_ff;

   logic [CHILD_W-1:0] child_sel;
   logic               child_present;
   logic               rd_en;
   logic [NODE_W-1:0]  rd_addr;
   logic [TOTAL_W:0]   sum;

   assign wr_entry.child   = {req_child_t, req_child_g, req_child_c, req_child_a};
   assign wr_entry.failure = req_failure_link;
   assign wr_entry.hits    = req_hit_count;

   // The row in rd_data_ff always belongs to node_ff while a scan runs.
   assign child_sel     = rd_data_ff.child[sym_ff];
   assign child_present = child_sel < CHILD_W'(NODE_COUNT);

   assign sts.cache_valid   = cache_valid_ff;
   assign sts.walk_needed   = (node_ff != '0) && !child_present;
   assign sts.limit_hit     = steps_ff >= STEP_W'(NODE_COUNT);
   assign sts.child_present = child_present;
   assign sts.rsp_free      = !rsp_valid_ff || rsp_ready;

   assign rd_en = cmd.scan_read || cmd.walk_fail || cmd.walk_root || cmd.take_child;

   always_comb begin
      rd_addr = scan_node_ff;
      node_in = node_ff;
      if (cmd.scan_start) begin
         node_in = scan_node_ff;
      end
      if (cmd.walk_fail) begin
         rd_addr = rd_data_ff.failure;
         node_in = rd_data_ff.failure;
      end else if (cmd.walk_root) begin
         rd_addr = '0;
         node_in = '0;
      end else if (cmd.take_child) begin
         rd_addr = child_sel[NODE_W-1:0];
         node_in = child_sel[NODE_W-1:0];
      end
   end

   always_comb begin
      steps_in = steps_ff;
      if (cmd.scan_start) begin
         steps_in = '0;
      end else if (cmd.walk_fail) begin
         steps_in = steps_ff + STEP_W'(1);
      end
   end

   // Saturating add of the reached node's hits.
   assign sum = {1'b0, total_ff} + {{(TOTAL_W + 1 - HIT_W){1'b0}}, rd_data_ff.hits};

   always_comb begin
      total_in       = total_ff;
      scan_node_in   = scan_node_ff;
      cache_valid_in = cache_valid_ff;
      if (cmd.restart) begin
         total_in       = '0;
         scan_node_in   = '0;
         cache_valid_in = 1'b0;
      end else if (cmd.load) begin
         if (req_node_index == scan_node_ff) begin
            cache_valid_in = 1'b0;
         end
      end else if (cmd.finish) begin
         total_in       = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
         scan_node_in   = node_ff;
         cache_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         node_mem[req_node_index] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= node_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_node_ff   <= '0;
         total_ff       <= '0;
         cache_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         scan_node_ff   <= scan_node_in;
         total_ff       <= total_in;
         cache_valid_ff <= cache_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff  <= node_in;
      steps_ff <= steps_in;
      if (cmd.scan_start) begin
         sym_ff <= req_symbol;
      end
      if (cmd.finish) begin
         rsp_hits_ff  <= rd_data_ff.hits;
         rsp_total_ff <= total_in;
         rsp_node_ff  <= node_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matches_here  = rsp_hits_ff;
   assign rsp_total_matches = rsp_total_ff;
   assign rsp_current_state = rsp_node_ff;

endmodule

`default_nettype wire

// ----- src/aho_corasick_dna_matcher.sv -----
// Aho-Corasick DNA matcher. Load, restart and ignored items produce no result. Scan
// item: idle accepts it; eval follows failure links, or returns to the root at the step
// limit, then takes the child; finish waits for a held result to be taken and loads
// the result register. No new item is accepted until the scan is back in idle;
// each step uses the single node-table read port. Reset clears scan position, total and
// result valid; the node table is not cleared and is undefined until loaded.
`default_nettype none
`include "aho_corasick_dna_matcher_defines.svh"

module aho_corasick_dna_matcher import acdm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   acdm_req_if.sink   req_if,
   acdm_rsp_if.source rsp_if
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;
   logic        req_ready;

   // The controller owns the handshake on the request side; each accepted
   // load, restart or scan becomes commands to the datapath.
   acdm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_opcode (req_if.opcode),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   assign req_if.ready = req_ready;

   // The datapath holds the node table, the walk node, the saturating total
   // and the result register, which decouples the result side so that the
   // next item can be taken while a result still waits.
   acdm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_node_index    (req_if.node_index),
      .req_child_a       (req_if.child_a),
      .req_child_c       (req_if.child_c),
      .req_child_g       (req_if.child_g),
      .req_child_t       (req_if.child_t),
      .req_failure_link  (req_if.failure_link),
      .req_hit_count     (req_if.hit_count),
      .req_symbol        (req_if.symbol),
      .rsp_valid         (rsp_if.valid),
      .rsp_ready         (rsp_if.ready),
      .rsp_matches_here  (rsp_if.matches_here),
      .rsp_total_matches (rsp_if.total_matches),
      .rsp_current_state (rsp_if.current_state)
   );

   // Never overwrite a result that has not been taken.
   `ACDM_ASSERT_NOW(a_finish_free, cmd.finish, sts.rsp_free, "result overwritten")
   // A finished scan shows a result in the next cycle.
   `ACDM_ASSERT_NEXT(a_finish_shows, cmd.finish, rsp_if.valid, "result lost")
   // At most one source drives the table read address.
   `ACDM_ASSERT_NOW(a_one_read, 1'b1,
      $onehot0({cmd.scan_read, cmd.walk_fail, cmd.walk_root, cmd.take_child}),
      "conflicting table reads")
   // No new item is taken while a failure walk is in progress.
   `ACDM_ASSERT_NOW(a_walk_busy, cmd.walk_fail || cmd.walk_root, !req_if.ready,
      "item taken during walk")

endmodule

`default_nettype wire

// ----- verif/acdm_match_checker.sv -----
// Checker for the Aho-Corasick DNA matcher: mirrors the node table and the
// scan position, predicts every scan result and compares the result channel.
// Depends on acdm_pkg, acdm_req_if and acdm_rsp_if.

module acdm_match_checker import acdm_pkg::*; (
   input  logic clock,
   input  logic reset,
   acdm_req_if  req_if,
   acdm_rsp_if  rsp_if,
   output int   fail_count,
   output int   pending_count
);

   typedef struct {
      logic [HIT_W-1:0]   hits;
      logic [TOTAL_W-1:0] total;
      logic [NODE_W-1:0]  state;
   } scan_result_type;

   localparam logic [CHILD_W-1:0] NO_CHILD = CHILD_W'(NODE_COUNT);

   node_entry_type     node_table [NODE_COUNT];
   logic [NODE_W-1:0]  scan_pos;
   logic [TOTAL_W-1:0] running_total;
   scan_result_type    expected_matches [$];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // Follow failure links while the child is absent, giving up on the walk
   // after NODE_COUNT hops, then take the child if there is one.
   function automatic logic [NODE_W-1:0] next_node(input logic [NODE_W-1:0] from,
                                                   input logic [SYM_W-1:0]  sym);
      logic [NODE_W-1:0] node;
      int                hops;
      node = from;
      hops = 0;
      while (node != '0 && node_table[node].child[sym] >= NO_CHILD) begin
         if (hops >= NODE_COUNT) begin
            node = '0;
            break;
         end
         node = node_table[node].failure;
         hops++;
      end
      if (node_table[node].child[sym] < NO_CHILD)
         node = node_table[node].child[sym][NODE_W-1:0];
      return node;
   endfunction

   always @(posedge clock) begin : watch
      scan_result_type  want;
      node_entry_type   entry;
      logic [TOTAL_W:0] sum;
      if (reset) begin
         scan_pos      = '0;
         running_total = '0;
         expected_matches.delete();
      end else begin
         // results first: a scan accepted at this edge cannot have its result yet
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_matches.size() == 0) begin
               report_mismatch("result with no scan waiting, current_state",
                               rsp_if.current_state, 0);
            end else begin
               want = expected_matches.pop_front();
               if (rsp_if.matches_here !== want.hits)
                  report_mismatch("matches_here", rsp_if.matches_here, want.hits);
               if (rsp_if.total_matches !== want.total)
                  report_mismatch("total_matches", rsp_if.total_matches, want.total);
               if (rsp_if.current_state !== want.state)
                  report_mismatch("current_state", rsp_if.current_state, want.state);
            end
         end
         if (req_if.valid && req_if.ready) begin
            case (req_if.opcode)
               OP_LOAD: begin
                  entry.child[0] = req_if.child_a;
                  entry.child[1] = req_if.child_c;
                  entry.child[2] = req_if.child_g;
                  entry.child[3] = req_if.child_t;
                  entry.failure  = req_if.failure_link;
                  entry.hits     = req_if.hit_count;
                  node_table[req_if.node_index] = entry;
               end
               OP_RESTART: begin
                  scan_pos      = '0;
                  running_total = '0;
               end
               OP_SCAN: begin
                  scan_pos      = next_node(scan_pos, req_if.symbol);
                  sum           = {1'b0, running_total}
                                + (TOTAL_W+1)'(node_table[scan_pos].hits);
                  running_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                  want.hits     = node_table[scan_pos].hits;
                  want.total    = running_total;
                  want.state    = scan_pos;
                  expected_matches.insert(expected_matches.size(), want);
               end
               default: ;
            endcase
         end
      end
      pending_count <= expected_matches.size();
   end

endmodule

// ----- verif/tb_aho_corasick_dna_matcher.sv -----
// Testbench top for the Aho-Corasick DNA matcher: clock, reset, stimulus,
// receiver back-pressure and the verdict. Checking lives in acdm_match_checker;
// depends on acdm_pkg, acdm_req_if, acdm_rsp_if and the block itself.

module tb_aho_corasick_dna_matcher;
   import acdm_pkg::*;

   // The block ignores opcode 3 altogether.
   localparam logic [OPCODE_W-1:0] OP_IDLE = 2'd3;

   localparam logic [SYM_W-1:0] SYM_A = 2'd0;
   localparam logic [SYM_W-1:0] SYM_C = 2'd1;
   localparam logic [SYM_W-1:0] SYM_G = 2'd2;
   localparam logic [SYM_W-1:0] SYM_T = 2'd3;

   localparam logic [CHILD_W-1:0] NO_CHILD = CHILD_W'(NODE_COUNT);
   localparam int ENTRY_W = $bits(node_entry_type);

   localparam int RANDOM_ITEMS = 1950;
   localparam int PHASE_COUNT  = 4;
   // Slowest honest run: about 2k items, two hop-limited walks of about a thousand
   // hops each, random walks of at most 60 hops, and sender gaps and receiver
   // stalls; taken several times over.
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [NODE_W-1:0]   node_index;
      node_entry_type      entry;
      logic [SYM_W-1:0]    symbol;
   } req_item_type;

   logic              clock;
   logic              reset;
   int                fail_count;
   int                pending_count;
   int unsigned       send_idle_pct = 0;
   int unsigned       rsp_stall_pct = 0;
   int unsigned       child_pct     = 60;
   int unsigned       random_items  = 0;
   int unsigned       cycle_count;
   logic [NODE_W-1:0] automaton_nodes [$];

   acdm_req_if req_if ();
   acdm_rsp_if rsp_if ();

   aho_corasick_dna_matcher i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   acdm_match_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result ends here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: redraw ready at every falling edge from the current stall rate.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Fill every field with noise; callers then set what the opcode uses, so the
   // fields that an item ignores still toggle.
   function automatic req_item_type random_item(input logic [OPCODE_W-1:0] op);
      req_item_type it;
      logic [95:0]  noise;
      noise         = {$urandom(), $urandom(), $urandom()};
      it.opcode     = op;
      it.entry      = noise[ENTRY_W-1:0];
      it.node_index = noise[ENTRY_W +: NODE_W];
      it.symbol     = noise[ENTRY_W+NODE_W +: SYM_W];
      return it;
   endfunction

   function automatic node_entry_type make_entry(input int a, input int c, input int g,
                                                 input int t, input int fail, input int hits);
      node_entry_type e;
      e.child[0] = CHILD_W'(a);
      e.child[1] = CHILD_W'(c);
      e.child[2] = CHILD_W'(g);
      e.child[3] = CHILD_W'(t);
      e.failure  = NODE_W'(fail);
      e.hits     = HIT_W'(hits);
      return e;
   endfunction

   function automatic logic [HIT_W-1:0] random_hits();
      case ($urandom_range(9))
         0:          return '0;
         1:          return '1;
         2, 3, 4, 5: return HIT_W'($urandom_range(3));
         default:    return HIT_W'($urandom());
      endcase
   endfunction

   // Children point only at nodes of the current automaton, so nothing unloaded
   // is ever read; absent children use the whole 1024..2047 range. Failure
   // links point strictly down the rank order, so every walk ends at the root.
   function automatic node_entry_type random_entry(input int unsigned rank);
      node_entry_type e;
      int unsigned    last;
      last = automaton_nodes.size() - 1;
      for (int k = 0; k < ALPHABET_SIZE; k++)
         e.child[k] = ($urandom_range(99) < child_pct)
                    ? CHILD_W'(automaton_nodes[$urandom_range(last)])
                    : NO_CHILD | CHILD_W'($urandom_range(NODE_COUNT - 1));
      e.failure = automaton_nodes[$urandom_range(rank == 0 ? last : rank - 1)];
      e.hits    = random_hits();
      return e;
   endfunction

   // Enter at a falling edge, leave at a falling edge with the item accepted.
   task automatic push_item(input req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid        = 1'b1;
      req_if.opcode       = it.opcode;
      req_if.node_index   = it.node_index;
      req_if.child_a      = it.entry.child[0];
      req_if.child_c      = it.entry.child[1];
      req_if.child_g      = it.entry.child[2];
      req_if.child_t      = it.entry.child[3];
      req_if.failure_link = it.entry.failure;
      req_if.hit_count    = it.entry.hits;
      req_if.symbol       = it.symbol;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      @(negedge clock);
      if (it.opcode != OP_IDLE)
         random_items++;
   endtask

   task automatic load_node(input logic [NODE_W-1:0] idx, input node_entry_type e);
      req_item_type it;
      it            = random_item(OP_LOAD);
      it.node_index = idx;
      it.entry      = e;
      push_item(it);
   endtask

   task automatic scan_symbol(input logic [SYM_W-1:0] sym);
      req_item_type it;
      it        = random_item(OP_SCAN);
      it.symbol = sym;
      push_item(it);
   endtask

   task automatic send_op(input logic [OPCODE_W-1:0] op);
      push_item(random_item(op));
   endtask

   // Hold the sender until every scan result has come back.
   task automatic drain_results();
      req_if.valid = 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   // Pick a fresh node set (root first, the top node now and then) and load
   // it in a shuffled order before any scan may touch it.
   task automatic build_automaton();
      bit          taken [NODE_COUNT];
      int unsigned size;
      int unsigned order [$];
      int unsigned j;
      int unsigned swap;
      logic [NODE_W-1:0] idx;
      automaton_nodes.delete();
      automaton_nodes.insert(automaton_nodes.size(), NODE_W'(0));
      taken[0] = 1'b1;
      if ($urandom_range(3) == 0) begin
         automaton_nodes.insert(automaton_nodes.size(), NODE_W'(NODE_COUNT - 1));
         taken[NODE_COUNT-1] = 1'b1;
      end
      size = ($urandom_range(7) == 0) ? 60 : $urandom_range(2, 24);
      while (automaton_nodes.size() < size) begin
         idx = NODE_W'($urandom_range(NODE_COUNT - 1));
         if (!taken[idx]) begin
            taken[idx] = 1'b1;
            automaton_nodes.insert(automaton_nodes.size(), idx);
         end
      end
      case ($urandom_range(2))
         0:       child_pct = 30;
         1:       child_pct = 60;
         default: child_pct = 90;
      endcase
      for (int r = 0; r < automaton_nodes.size(); r++)
         order.insert(order.size(), r);
      for (int r = order.size() - 1; r > 0; r--) begin
         j        = $urandom_range(r);
         swap     = order[r];
         order[r] = order[j];
         order[j] = swap;
      end
      foreach (order[r])
         load_node(automaton_nodes[order[r]], random_entry(order[r]));
   endtask

   // One automaton, then a burst of mostly scans with some reloads (of random
   // nodes of the automaton), restarts and ignored items mixed in.
   task automatic run_episode();
      int unsigned       ops;
      int unsigned       pick;
      int unsigned       rank;
      logic [SYM_W-1:0]  favoured;
      if ($urandom_range(2) == 0)
         drain_results();
      build_automaton();
      send_op(OP_RESTART);
      favoured = SYM_W'($urandom_range(3));
      ops      = $urandom_range(20, 80);
      repeat (ops) begin
         pick = $urandom_range(99);
         if (pick < 76) begin
            scan_symbol($urandom_range(1) ? favoured : SYM_W'($urandom_range(3)));
         end else if (pick < 86) begin
            rank = $urandom_range(automaton_nodes.size() - 1);
            load_node(automaton_nodes[rank], random_entry(rank));
         end else if (pick < 93) begin
            send_op(OP_RESTART);
         end else begin
            send_op(OP_IDLE);
         end
      end
   endtask

   initial begin : stimulus
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.opcode       = OP_LOAD;
      req_if.node_index   = '0;
      req_if.child_a      = '0;
      req_if.child_c      = '0;
      req_if.child_g      = '0;
      req_if.child_t      = '0;
      req_if.failure_link = '0;
      req_if.hit_count    = '0;
      req_if.symbol       = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: a small hand-built automaton. Nodes 1 and 2 fail to each
      // other and neither has a G child, so a G scan from either walks the
      // loop until the hop limit and lands back at the root.
      load_node(0,    make_entry(1023, 1, 2047, 1024, 1023, 0));
      load_node(1023, make_entry(0, 1024, 1, 1023, 0, 65535));
      load_node(1,    make_entry(2, 1500, 1024, 1023, 2, 1));
      load_node(2,    make_entry(1, 1, 1024, 1700, 1, 7));
      send_op(OP_RESTART);
      scan_symbol(SYM_A);    // root to the top node, largest hit count
      scan_symbol(SYM_A);    // child link of zero: back to the root
      scan_symbol(SYM_C);
      scan_symbol(SYM_G);    // endless failure walk
      scan_symbol(SYM_C);
      scan_symbol(SYM_T);
      scan_symbol(SYM_G);
      scan_symbol(SYM_C);    // one failure hop, then the child
      scan_symbol(SYM_T);
      // rewrite the node currently being scanned
      load_node(1023, make_entry(1024, 2, 1025, 0, 1, 12));
      scan_symbol(SYM_A);
      send_op(OP_IDLE);
      scan_symbol(SYM_G);    // endless walk again, this time from node 2
      send_op(OP_RESTART);
      scan_symbol(SYM_C);
      drain_results();

      // Random part, phase by phase: no idling, sender idle, receiver
      // stalling, then a little of both.
      random_items = 0;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 82;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 82;
            end
            default: begin
               send_idle_pct = 20;
               rsp_stall_pct = 20;
            end
         endcase
         while (random_items < RANDOM_ITEMS * (phase + 1) / PHASE_COUNT)
            run_episode();
      end

      // Drop valid, let the last results in, then give the verdict.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
